FILE: rtl/deqc_pkg.sv
// Shared types and constants of the double-ended queue checker.
`timescale 1ns / 1ps

package deqc_pkg;

    // Default number of entries in the circular store.
    localparam int CAPACITY_DEF = 1024;

    // Fixed field widths of the request and result channels.
    localparam int KIND_W = 2;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 11;

    // Operation codes carried in the kind field.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_POP_FRONT  = 2'd1,
        KIND_PUSH_BACK  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;  // take the request and start the store read
        logic commit;  // finish the operation and load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // result register empty or being emptied this cycle
    } ctrl_sts_t;

endpackage

FILE: rtl/deqc_if.sv
// Request and result channel interfaces of the double-ended queue checker.
`timescale 1ns / 1ps

interface deqc_req_if;
    logic                                valid;
    logic                                ready;
    logic        [deqc_pkg::KIND_W-1:0]  kind;
    logic signed [deqc_pkg::DATA_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deqc_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [deqc_pkg::DATA_W-1:0]  popped_value;
    logic                                was_empty;
    logic                                push_dropped;
    logic                                pop_matched;
    logic                                all_correct;
    logic        [deqc_pkg::OCC_W-1:0]   occupancy;

    modport source (output valid, output popped_value, output was_empty,
                    output push_dropped, output pop_matched, output all_correct,
                    output occupancy, input ready);
    modport sink   (input valid, input popped_value, input was_empty,
                    input push_dropped, input pop_matched, input all_correct,
                    input occupancy, output ready);
endinterface

FILE: rtl/deqc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module deqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/deqc_ctrl.sv
// Controller state machine of the double-ended queue checker.
`timescale 1ns / 1ps

module deqc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  deqc_pkg::ctrl_sts_t sts,
    output deqc_pkg::ctrl_cmd_t cmd
);

    deqc_pkg::state_t state_reg;
    deqc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deqc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            deqc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = deqc_pkg::ST_EXEC;
                end
            end
            deqc_pkg::ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = deqc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = deqc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        req_ready  = 1'b0;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            deqc_pkg::ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            deqc_pkg::ST_EXEC:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    // A request is only taken from the idle state, and the operation it starts
    // is always finished in the cycle after it at the earliest.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == deqc_pkg::ST_EXEC))
        else $error("accepted request did not start execution");

    // A commit always returns the controller to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == deqc_pkg::ST_IDLE))
        else $error("commit did not return to idle");

    // The controller never takes a request and commits in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.commit))
        else $error("accept and commit overlap");
`endif

endmodule

FILE: rtl/deqc_dpath.sv
// Datapath of the double-ended queue checker: indices, count, flag and result.
`timescale 1ns / 1ps

module deqc_dpath #(
    parameter int CAPACITY = deqc_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  deqc_pkg::ctrl_cmd_t cmd,
    output deqc_pkg::ctrl_sts_t sts,
    input  logic [deqc_pkg::KIND_W-1:0] req_kind,
    input  logic signed [deqc_pkg::DATA_W-1:0] req_value,
    deqc_rsp_if.source          rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = deqc_pkg::DATA_W;
    localparam int OW = deqc_pkg::OCC_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    // Request held for the duration of the operation.
    deqc_pkg::kind_t   kind_reg;
    logic [DW-1:0]     value_reg;

    // Queue state.
    logic [IW-1:0]     front_reg, front_next;
    logic [IW-1:0]     back_reg,  back_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              flag_reg,  flag_next;

    // Result register.
    logic              out_valid_reg;
    logic [DW-1:0]     popped_reg,  popped_next;
    logic              empty_reg,   empty_next;
    logic              dropped_reg, dropped_next;
    logic              matched_reg, matched_next;
    logic [OW-1:0]     occ_reg,     occ_next;

    // Store interface.
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [IW-1:0]     ram_raddr;
    logic [DW-1:0]     ram_rdata;

    logic              is_push;
    logic              is_empty;
    logic              is_full;
    logic [IW-1:0]     front_dec;
    logic [IW-1:0]     back_inc;
    logic [IW-1:0]     front_inc;
    logic [IW-1:0]     back_dec;
    logic [OW+CW-1:0]  occ_wide;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg  <= deqc_pkg::kind_t'(req_kind);
            value_reg <= req_value;
        end
    end

    assign is_push  = (kind_reg == deqc_pkg::KIND_PUSH_FRONT) ||
                      (kind_reg == deqc_pkg::KIND_PUSH_BACK);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);

    assign front_dec = (front_reg == '0)      ? LAST_IDX : front_reg - IW'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0      : front_reg + IW'(1);
    assign back_inc  = (back_reg == LAST_IDX)  ? '0      : back_reg + IW'(1);
    assign back_dec  = (back_reg == '0)       ? LAST_IDX : back_reg - IW'(1);

    // The store read is issued as the request is taken, from the index that
    // the pop will consume.
    assign ram_raddr = (deqc_pkg::kind_t'(req_kind) == deqc_pkg::KIND_POP_FRONT)
                       ? front_reg : back_reg;
    assign ram_we    = cmd.commit && is_push && !is_full;
    assign ram_waddr = (kind_reg == deqc_pkg::KIND_PUSH_FRONT) ? front_dec : back_inc;

    deqc_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .re    (cmd.accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        front_next   = front_reg;
        back_next    = back_reg;
        count_next   = count_reg;
        flag_next    = flag_reg;
        popped_next  = '0;
        empty_next   = 1'b0;
        dropped_next = 1'b0;
        matched_next = 1'b1;
        if (is_push)
        begin
            if (is_full)
            begin
                dropped_next = 1'b1;
                matched_next = 1'b0;
                flag_next    = 1'b0;
            end
            else
            begin
                if (kind_reg == deqc_pkg::KIND_PUSH_FRONT)
                begin
                    front_next = front_dec;
                end
                else
                begin
                    back_next = back_inc;
                end
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (is_empty)
            begin
                popped_next = '1;
                empty_next  = 1'b1;
            end
            else
            begin
                popped_next = ram_rdata;
                if (kind_reg == deqc_pkg::KIND_POP_FRONT)
                begin
                    front_next = front_inc;
                end
                else
                begin
                    back_next = back_dec;
                end
                count_next = count_reg - CW'(1);
            end
            matched_next = (popped_next == value_reg);
            if (!matched_next)
            begin
                flag_next = 1'b0;
            end
        end
        occ_wide = {{OW{1'b0}}, count_next};
        occ_next = occ_wide[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            back_reg      <= LAST_IDX;
            count_reg     <= '0;
            flag_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                front_reg     <= front_next;
                back_reg      <= back_next;
                count_reg     <= count_next;
                flag_reg      <= flag_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            popped_reg  <= popped_next;
            empty_reg   <= empty_next;
            dropped_reg <= dropped_next;
            matched_reg <= matched_next;
            occ_reg     <= occ_next;
        end
    end

    assign sts.out_free     = !out_valid_reg || rsp.ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.was_empty    = empty_reg;
    assign rsp.push_dropped = dropped_reg;
    assign rsp.pop_matched  = matched_reg;
    assign rsp.all_correct  = flag_reg;
    assign rsp.occupancy    = occ_reg;

`ifndef SYNTH
    // The count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count beyond capacity");

    // An empty queue always has the back index one before the front index.
    assert property (@(posedge clk) disable iff (!rst_n)
        is_empty |-> (back_inc == front_reg))
        else $error("indices inconsistent with an empty queue");

    // Once cleared, the correctness flag stays cleared until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !flag_reg |=> !flag_reg)
        else $error("correctness flag set again");

    // A pop from a non-empty queue removes exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !is_push && !is_empty) |=>
        (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not remove one entry");
`endif

endmodule

FILE: rtl/double_ended_queue_checker.sv
// Top level of the double-ended queue checker.
`timescale 1ns / 1ps

// Double-ended queue checker. Each request names one of four operations, push
// front, pop front, push back or pop back, and carries a value: the data for
// a push, the expected data for a pop. The queue lives in a circular store of
// CAPACITY entries held in one RAM, with front and back indices and an entry
// count in registers. Every request yields exactly one result: the popped
// value (minus one when a pop finds the queue empty, zero for a push), the
// empty and dropped indications, whether the pop matched its expected value
// (or the push was taken), a sticky all-correct flag, and the occupancy after
// the operation. A push into a full queue is dropped and clears the flag, as
// does any pop whose result differs from the expected value. In the cycle a
// request is accepted the store read is issued at the index the pop will
// consume; once the result register is free, the registered read data is
// compared, the indices, count and store are updated and the result register
// is loaded. The result register holds a finished result while the next
// request is accepted; a request stays in execution only while the result
// register is still occupied by an earlier result that has not been taken.
// The store needs no clearing after reset: a pop only ever reads an entry an
// earlier push wrote, so the block is ready as soon as reset is released.
module double_ended_queue_checker #(
    parameter int CAPACITY = deqc_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    deqc_req_if.sink   req,
    deqc_rsp_if.source rsp
);

    // Command and status between the controller and the datapath.
    deqc_pkg::ctrl_cmd_t cmd;
    deqc_pkg::ctrl_sts_t sts;

    // The controller sequences each request: it takes the request while idle
    // and commits it once the result register can accept the outcome.
    deqc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the queue state, the store and the result register.
    deqc_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_kind  (req.kind),
        .req_value (req.value),
        .rsp       (rsp)
    );

endmodule
